/* rtl/md5_pkg.sv */
// MD5 stream hash package: round constants, rotation table, round function.
// Depends on nothing; imported by every module of the md5_stream_hash block.
package md5_pkg;

    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hefcdab89;
    localparam logic [31:0] IV_C = 32'h98badcfe;
    localparam logic [31:0] IV_D = 32'h10325476;
    localparam logic [7:0]  PAD_BYTE = 8'h80;
    localparam logic [5:0]  LEN_OFFSET = 6'd56;

    // Commands from controller to datapath
    typedef struct packed {
        logic       buf_write;   // write wr_byte at fill index
        logic [7:0] wr_byte;
        logic       add_bits;    // bit count += 8
        logic       start_comp;  // begin compression (round 0)
        logic       round_step;  // execute one round
        logic       fold;        // add working vars into chain
        logic       reinit;      // restore IV, clear count and fill
    } md5_cmd_t;

    typedef struct packed {
        logic [5:0] fill;
        logic [5:0] round;
    } md5_stat_t;

    function automatic logic [31:0] md5_k(input logic [5:0] i);
        logic [31:0] r;
        case (i)
            6'd0:  r = 32'hd76aa478; 6'd1:  r = 32'he8c7b756; 6'd2:  r = 32'h242070db;
            6'd3:  r = 32'hc1bdceee; 6'd4:  r = 32'hf57c0faf; 6'd5:  r = 32'h4787c62a;
            6'd6:  r = 32'ha8304613; 6'd7:  r = 32'hfd469501; 6'd8:  r = 32'h698098d8;
            6'd9:  r = 32'h8b44f7af; 6'd10: r = 32'hffff5bb1; 6'd11: r = 32'h895cd7be;
            6'd12: r = 32'h6b901122; 6'd13: r = 32'hfd987193; 6'd14: r = 32'ha679438e;
            6'd15: r = 32'h49b40821; 6'd16: r = 32'hf61e2562; 6'd17: r = 32'hc040b340;
            6'd18: r = 32'h265e5a51; 6'd19: r = 32'he9b6c7aa; 6'd20: r = 32'hd62f105d;
            6'd21: r = 32'h02441453; 6'd22: r = 32'hd8a1e681; 6'd23: r = 32'he7d3fbc8;
            6'd24: r = 32'h21e1cde6; 6'd25: r = 32'hc33707d6; 6'd26: r = 32'hf4d50d87;
            6'd27: r = 32'h455a14ed; 6'd28: r = 32'ha9e3e905; 6'd29: r = 32'hfcefa3f8;
            6'd30: r = 32'h676f02d9; 6'd31: r = 32'h8d2a4c8a; 6'd32: r = 32'hfffa3942;
            6'd33: r = 32'h8771f681; 6'd34: r = 32'h6d9d6122; 6'd35: r = 32'hfde5380c;
            6'd36: r = 32'ha4beea44; 6'd37: r = 32'h4bdecfa9; 6'd38: r = 32'hf6bb4b60;
            6'd39: r = 32'hbebfbc70; 6'd40: r = 32'h289b7ec6; 6'd41: r = 32'heaa127fa;
            6'd42: r = 32'hd4ef3085; 6'd43: r = 32'h04881d05; 6'd44: r = 32'hd9d4d039;
            6'd45: r = 32'he6db99e5; 6'd46: r = 32'h1fa27cf8; 6'd47: r = 32'hc4ac5665;
            6'd48: r = 32'hf4292244; 6'd49: r = 32'h432aff97; 6'd50: r = 32'hab9423a7;
            6'd51: r = 32'hfc93a039; 6'd52: r = 32'h655b59c3; 6'd53: r = 32'h8f0ccc92;
            6'd54: r = 32'hffeff47d; 6'd55: r = 32'h85845dd1; 6'd56: r = 32'h6fa87e4f;
            6'd57: r = 32'hfe2ce6e0; 6'd58: r = 32'ha3014314; 6'd59: r = 32'h4e0811a1;
            6'd60: r = 32'hf7537e82; 6'd61: r = 32'hbd3af235; 6'd62: r = 32'h2ad7d2bb;
            default: r = 32'heb86d391;
        endcase
        return r;
    endfunction

    function automatic logic [4:0] md5_rot(input logic [5:0] i);
        logic [4:0] r;
        case ({i[5:4], i[1:0]})
            4'd0:  r = 5'd7;  4'd1:  r = 5'd12; 4'd2:  r = 5'd17; 4'd3:  r = 5'd22;
            4'd4:  r = 5'd5;  4'd5:  r = 5'd9;  4'd6:  r = 5'd14; 4'd7:  r = 5'd20;
            4'd8:  r = 5'd4;  4'd9:  r = 5'd11; 4'd10: r = 5'd16; 4'd11: r = 5'd23;
            4'd12: r = 5'd6;  4'd13: r = 5'd10; 4'd14: r = 5'd15; default: r = 5'd21;
        endcase
        return r;
    endfunction

    // Message word index used by round i
    function automatic logic [3:0] md5_g(input logic [5:0] i);
        logic [3:0] r;
        case (i[5:4])
            2'd0:    r = i[3:0];
            2'd1:    r = 4'(5 * i[3:0] + 1);
            2'd2:    r = 4'(3 * i[3:0] + 5);
            default: r = 4'(7 * i[3:0]);
        endcase
        return r;
    endfunction

    function automatic logic [31:0] md5_f(input logic [1:0] grp,
                                          input logic [31:0] b, input logic [31:0] c,
                                          input logic [31:0] d);
        logic [31:0] r;
        case (grp)
            2'd0:    r = (b & c) | (~b & d);
            2'd1:    r = (b & d) | (c & ~d);
            2'd2:    r = b ^ c ^ d;
            default: r = c ^ (b | ~d);
        endcase
        return r;
    endfunction

endpackage

/* rtl/md5_datapath.sv */
// MD5 datapath: block buffer memory, bit count, fill index, round registers, chain.
// Depends on md5_pkg for command/status types and round tables.
module md5_datapath
    import md5_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  md5_cmd_t    cmd,
    output md5_stat_t   stat,
    output logic [7:0]  len_byte,
    output logic [31:0] chain0,
    output logic [31:0] chain1,
    output logic [31:0] chain2,
    output logic [31:0] chain3
);

    // Block buffer held as 16 little-endian words; one byte written per cycle while buf_write is set
    logic [31:0] buf_mem [16];
    logic [5:0]  fill_reg;
    logic [63:0] count_reg;
    logic [5:0]  round_reg;
    logic [31:0] a_reg, b_reg, c_reg, d_reg;
    logic [31:0] h_reg [4];
    logic [31:0] word_g;
    logic [31:0] sum, rot;
    logic [4:0]  sh;

    // Write byte lanes
    always_ff @(posedge clk)
    begin
        if (cmd.buf_write)
        begin
            buf_mem[fill_reg[5:2]][8*fill_reg[1:0] +: 8] <= cmd.wr_byte;
        end
    end

    // Fill index and bit count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (cmd.buf_write)
            begin
                fill_reg <= fill_reg + 6'd1;
            end
            if (cmd.add_bits)
            begin
                count_reg <= count_reg + 64'd8;
            end
            if (cmd.reinit)
            begin
                fill_reg  <= '0;
                count_reg <= '0;
            end
        end
    end

    // Length byte source: byte (fill - 56) of the saved count
    assign len_byte = count_reg[8*fill_reg[2:0] +: 8];

    // One round per cycle
    assign word_g = buf_mem[md5_g(round_reg)];
    assign sum    = a_reg + md5_f(round_reg[5:4], b_reg, c_reg, d_reg) + md5_k(round_reg) + word_g;
    assign sh     = md5_rot(round_reg);
    assign rot    = (sum << sh) | (sum >> (6'd32 - {1'b0, sh}));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            round_reg <= '0;
            h_reg[0] <= IV_A; h_reg[1] <= IV_B; h_reg[2] <= IV_C; h_reg[3] <= IV_D;
            a_reg <= '0; b_reg <= '0; c_reg <= '0; d_reg <= '0;
        end
        else
        begin
            if (cmd.start_comp)
            begin
                round_reg <= '0;
                a_reg <= h_reg[0]; b_reg <= h_reg[1];
                c_reg <= h_reg[2]; d_reg <= h_reg[3];
            end
            else if (cmd.round_step)
            begin
                round_reg <= round_reg + 6'd1;
                a_reg <= d_reg;
                d_reg <= c_reg;
                c_reg <= b_reg;
                b_reg <= b_reg + rot;
            end
            if (cmd.fold)
            begin
                h_reg[0] <= h_reg[0] + a_reg;
                h_reg[1] <= h_reg[1] + b_reg;
                h_reg[2] <= h_reg[2] + c_reg;
                h_reg[3] <= h_reg[3] + d_reg;
            end
            if (cmd.reinit)
            begin
                h_reg[0] <= IV_A; h_reg[1] <= IV_B; h_reg[2] <= IV_C; h_reg[3] <= IV_D;
            end
        end
    end

    assign stat.fill     = fill_reg;
    assign stat.round    = round_reg;
    assign chain0 = h_reg[0];
    assign chain1 = h_reg[1];
    assign chain2 = h_reg[2];
    assign chain3 = h_reg[3];

endmodule

/* rtl/md5_ctrl.sv */
// MD5 controller: input handshake, padding sequencer, round sequencing, digest output.
// Depends on md5_pkg for command/status types.
module md5_ctrl
    import md5_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        byte_present,
    input  logic        end_of_message,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  word_index,
    output logic        last_word,
    output logic [1:0]  sel_word,
    output md5_cmd_t    cmd,
    input  md5_stat_t   stat,
    input  logic [7:0]  len_byte
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_COMP  = 7'b0000010,
        S_FOLD  = 7'b0000100,
        S_PAD   = 7'b0001000,
        S_ZERO  = 7'b0010000,
        S_LEN   = 7'b0100000,
        S_OUT   = 7'b1000000
    } state_t;

    state_t      state_reg, state_next;
    state_t      ret_reg, ret_next;     // where to resume after the current compression
    logic [1:0]  idx_reg, idx_next;
    logic        accept;

    assign in_stall   = (state_reg != S_IDLE);
    assign accept     = in_valid && !in_stall;
    assign out_valid  = (state_reg == S_OUT);
    assign word_index = idx_reg;
    assign last_word  = (idx_reg == 2'd3);
    assign sel_word   = idx_reg;

    // Sequence padding, rounds and digest transactions
    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        idx_next   = idx_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (byte_present)
                    begin
                        cmd.buf_write = 1'b1;
                        cmd.wr_byte   = data_byte;
                        cmd.add_bits  = 1'b1;
                        if (stat.fill == 6'd63)
                        begin
                            cmd.start_comp = 1'b1;
                            state_next = S_COMP;
                            if (end_of_message)
                            begin
                                ret_next = S_PAD;
                            end
                            else
                            begin
                                ret_next = S_IDLE;
                            end
                        end
                        else if (end_of_message)
                        begin
                            state_next = S_PAD;
                        end
                    end
                    else if (end_of_message)
                    begin
                        state_next = S_PAD;
                    end
                end
            end
            S_PAD:
            begin
                cmd.buf_write = 1'b1;
                cmd.wr_byte   = PAD_BYTE;
                if (stat.fill == 6'd63)
                begin
                    cmd.start_comp = 1'b1;
                    ret_next   = S_ZERO;
                    state_next = S_COMP;
                end
                else
                begin
                    state_next = S_ZERO;
                end
            end
            S_ZERO:
            begin
                if (stat.fill == LEN_OFFSET)
                begin
                    state_next = S_LEN;
                end
                else
                begin
                    cmd.buf_write = 1'b1;
                    cmd.wr_byte   = 8'h00;
                    if (stat.fill == 6'd63)
                    begin
                        cmd.start_comp = 1'b1;
                        ret_next   = S_ZERO;
                        state_next = S_COMP;
                    end
                end
            end
            S_LEN:
            begin
                cmd.buf_write = 1'b1;
                cmd.wr_byte   = len_byte;
                if (stat.fill == 6'd63)
                begin
                    cmd.start_comp = 1'b1;
                    ret_next   = S_OUT;
                    state_next = S_COMP;
                end
            end
            S_COMP:
            begin
                cmd.round_step = 1'b1;
                if (stat.round == 6'd63)
                begin
                    state_next = S_FOLD;
                end
            end
            S_FOLD:
            begin
                // Fold the block, then resume input, padding or digest output
                cmd.fold   = 1'b1;
                state_next = ret_reg;
            end
            S_OUT:
            begin
                if (!out_stall)
                begin
                    idx_next = idx_reg + 2'd1;
                    if (idx_reg == 2'd3)
                    begin
                        cmd.reinit = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ret_reg   <= S_IDLE;
            idx_reg   <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            idx_reg   <= idx_next;
        end
    end

endmodule

/* rtl/md5_stream_hash.sv */
// MD5 stream hash top level: joins controller and datapath, drives digest ports.
// Depends on md5_pkg, md5_ctrl and md5_datapath.
//
// Streaming MD5 (RFC 1321). One message byte is taken per transaction; a byte
// transaction that completes a 64-byte block starts its compression and stalls
// input through 64 rounds in one shared round unit and the fold. An
// end-of-message transaction pads and appends the length, at most one byte per
// cycle, running one or two further compressions, then presents the four digest
// words low word first and restores the initial chaining values.
module md5_stream_hash
    import md5_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        byte_present,
    input  logic        end_of_message,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] digest_word,
    output logic [1:0]  word_index,
    output logic        last_word
);

    md5_cmd_t    cmd;
    md5_stat_t   stat;
    logic [7:0]  len_byte;
    logic [1:0]  sel_word;
    logic [31:0] chain0, chain1, chain2, chain3;

    md5_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .data_byte(data_byte), .byte_present(byte_present),
        .end_of_message(end_of_message),
        .out_valid(out_valid), .out_stall(out_stall),
        .word_index(word_index), .last_word(last_word),
        .sel_word(sel_word), .cmd(cmd), .stat(stat), .len_byte(len_byte)
    );

    md5_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat), .len_byte(len_byte),
        .chain0(chain0), .chain1(chain1), .chain2(chain2), .chain3(chain3)
    );

    // Select the digest word for the current transaction
    always_comb
    begin
        case (sel_word)
            2'd0:    digest_word = chain0;
            2'd1:    digest_word = chain1;
            2'd2:    digest_word = chain2;
            default: digest_word = chain3;
        endcase
    end

endmodule
